/* rtl/mpht_pkg.sv */
// Shared types, codes and per-row constant tables of the prime hash table.
package mpht_pkg;

   localparam int PRIME_COUNT   = 64;
   localparam int PRIME_IDX_W   = 6;
   localparam int PRIME_W       = 11;
   localparam int CHUNK_W       = 16;
   localparam int CHUNK_COUNT   = 4;
   localparam int MUL_W         = 30;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int FOLD_W        = CHUNK_W + PRIME_W;
   localparam int ACC_W         = FOLD_W + 2;
   localparam int BARRETT_SHIFT = 40;
   localparam int RECIP_W       = 30;
   localparam int QUOT_W        = 19;
   localparam logic [63:0] HASH_FACTOR = 64'd5381;

   localparam logic [1:0] KIND_GET     = 2'd0;
   localparam logic [1:0] KIND_SET     = 2'd1;
   localparam logic [1:0] KIND_REPLACE = 2'd2;
   localparam logic [1:0] KIND_REMOVE  = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_EXISTS    = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_INVALID   = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] read_value;
      logic [13:0] entry_count;
   } rsp_type;

   typedef logic [PRIME_W-1:0] prime_table_type [PRIME_COUNT];
   typedef logic [RECIP_W-1:0] recip_table_type [PRIME_COUNT];

   localparam prime_table_type PRIME_TABLE = '{
      11'd1511, 11'd1523, 11'd1531, 11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567,
      11'd1571, 11'd1579, 11'd1583, 11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613,
      11'd1619, 11'd1621, 11'd1627, 11'd1637, 11'd1657, 11'd1663, 11'd1667, 11'd1669,
      11'd1693, 11'd1697, 11'd1699, 11'd1709, 11'd1721, 11'd1723, 11'd1733, 11'd1741,
      11'd1747, 11'd1753, 11'd1759, 11'd1777, 11'd1783, 11'd1787, 11'd1789, 11'd1801,
      11'd1811, 11'd1823, 11'd1831, 11'd1847, 11'd1861, 11'd1867, 11'd1871, 11'd1873,
      11'd1877, 11'd1879, 11'd1889, 11'd1901, 11'd1907, 11'd1913, 11'd1931, 11'd1933,
      11'd1949, 11'd1951, 11'd1973, 11'd1979, 11'd1987, 11'd1993, 11'd1997, 11'd1999
   };

   // Shift-subtract long division, used only to build the tables below.
   function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den,
                                            input logic want_rem);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         quo = {quo[62:0], 1'b0};
         if (rem >= den) begin
            rem    = rem - den;
            quo[0] = 1'b1;
         end
      end
      return want_rem ? rem : quo;
   endfunction

   // 2^shift mod prime, per row
   function automatic prime_table_type make_weight(input int unsigned shift);
      prime_table_type t;
      for (int r = 0; r < PRIME_COUNT; r++) begin
         t[r] = PRIME_W'(long_div(64'd1 << shift, 64'(PRIME_TABLE[r]), 1'b1));
      end
      return t;
   endfunction

   // floor(2^BARRETT_SHIFT / prime) + 1, exact quotient for dividends below 2^ACC_W
   function automatic recip_table_type make_recip();
      recip_table_type t;
      for (int r = 0; r < PRIME_COUNT; r++) begin
         t[r] = RECIP_W'(long_div(64'd1 << BARRETT_SHIFT, 64'(PRIME_TABLE[r]), 1'b0) + 64'd1);
      end
      return t;
   endfunction

   localparam prime_table_type WEIGHT16 = make_weight(16);
   localparam prime_table_type WEIGHT32 = make_weight(32);
   localparam prime_table_type WEIGHT48 = make_weight(48);
   localparam recip_table_type RECIP    = make_recip();

   function automatic int unsigned slot_total(input int unsigned rows);
      int unsigned s;
      s = 0;
      for (int r = 0; r < PRIME_COUNT; r++) begin
         if (r < rows) s += PRIME_TABLE[r];
      end
      return s;
   endfunction

endpackage

/* rtl/mpht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/multilevel_prime_hash_table.sv */
// Multi-level prime-modulo key-value hash table, top level.
// Each request probes rows 0..LINES-1 in turn (LINES above 64 is capped at 64 rows); for
// each row the one shared 30x30 multiplier forms four 16-bit folds of the hashed key, then a
// Barrett quotient and its back-multiply to get the row remainder; the slot RAMs are then
// read and the stored key compared. A hit stops the scan, and so does the last row; key
// zero is answered without probing. req_stall is high while a request is in work; a result
// waiting in the output register does not hold off the next request. After reset a clearing
// pass empties every slot of the key RAM (12336 slots at LINES=8), one slot per cycle, with
// requests stalled.
module multilevel_prime_hash_table #(
   parameter int LINES      = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mpht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mpht_pkg::rsp_type rsp_data
);

   import mpht_pkg::*;

   localparam int ROWS    = (LINES > PRIME_COUNT) ? PRIME_COUNT : LINES;
   localparam int TOTAL   = int'(slot_total(ROWS));
   localparam int ADDR_W  = $clog2(TOTAL);
   localparam int COUNT_W = $clog2(TOTAL + 1);
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [63:0]      HASH_OFFSET = 64'(LINES) * HASH_FACTOR;
   localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_HASH   = 3'd2;
   localparam logic [2:0] ST_PROBE  = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_OUTPUT = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [2:0]            step_ff, step_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [1:0]            kind_ff, kind_in;
   logic [63:0]           key_ff, key_in;
   logic [63:0]           hash_ff, hash_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  free_found_ff, free_found_in;
   logic [ADDR_W-1:0]     free_addr_ff, free_addr_in;

   // pending outcome, applied when the result is loaded
   logic [2:0]            res_status_ff, res_status_in;
   logic [31:0]           res_read_ff, res_read_in;
   logic                  wr_key_en_ff, wr_key_en_in;
   logic                  wr_val_en_ff, wr_val_en_in;
   logic [ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic [63:0]           wr_key_ff, wr_key_in;
   logic                  cnt_inc_ff, cnt_inc_in;
   logic                  cnt_dec_ff, cnt_dec_in;

   logic [PRIME_IDX_W-1:0] tbl_idx;
   logic [PRIME_W-1:0]     prime;
   logic [PRIME_W-1:0]     weight;
   logic [MUL_W-1:0]       op_a, op_b;
   logic [ACC_W-1:0]       rem_full;
   logic [PRIME_W-1:0]     rem;
   logic                   fire;
   logic                   clearing;

   logic                   key_we;
   logic [ADDR_W-1:0]      key_waddr;
   logic [63:0]            key_wdata;
   logic [63:0]            key_rd;
   logic [VALUE_BITS-1:0]  val_rd;
   logic                   match, empty, last;

   assign tbl_idx  = PRIME_IDX_W'(row_ff);
   assign prime    = PRIME_TABLE[tbl_idx];
   assign rem_full = acc_ff - prod_ff[ACC_W-1:0];
   assign rem      = rem_full[PRIME_W-1:0];
   assign fire     = (state_ff == ST_OUTPUT) && (!rsp_valid_ff || !rsp_stall);
   assign clearing = (state_ff == ST_CLEAR);
   assign match    = (key_rd == key_ff);
   assign empty    = (key_rd == 64'd0);
   assign last     = (row_ff == LAST_ROW);

   // shared multiplier operand select
   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    weight = PRIME_W'(1);
         2'd1:    weight = WEIGHT16[tbl_idx];
         2'd2:    weight = WEIGHT32[tbl_idx];
         default: weight = WEIGHT48[tbl_idx];
      endcase
      case (step_ff) inside
         3'd0, 3'd1, 3'd2, 3'd3: begin
            op_a = MUL_W'(hash_ff[CHUNK_W*step_ff[1:0] +: CHUNK_W]);
            op_b = MUL_W'(weight);
         end
         3'd5: begin
            op_a = MUL_W'(acc_ff);
            op_b = MUL_W'(RECIP[tbl_idx]);
         end
         3'd6: begin
            op_a = MUL_W'(prod_ff[BARRETT_SHIFT +: QUOT_W]);
            op_b = MUL_W'(prime);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      step_in       = step_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      hash_in       = hash_ff;
      val_in        = val_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      addr_in       = addr_ff;
      free_found_in = free_found_ff;
      free_addr_in  = free_addr_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      wr_key_en_in  = wr_key_en_ff;
      wr_val_en_in  = wr_val_en_ff;
      wr_addr_in    = wr_addr_ff;
      wr_key_in     = wr_key_ff;
      cnt_inc_in    = cnt_inc_ff;
      cnt_dec_in    = cnt_dec_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = ADDR_W'(clr_ff + ADDR_W'(1));
            if (clr_ff == ADDR_W'(TOTAL - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in       = req_data.kind;
               key_in        = req_data.key;
               hash_in       = req_data.key + HASH_OFFSET;
               val_in        = VALUE_BITS'(req_data.value);
               row_in        = '0;
               base_in       = '0;
               step_in       = '0;
               free_found_in = 1'b0;
               if (req_data.key == 64'd0) begin
                  res_status_in = STATUS_INVALID;
                  res_read_in   = '0;
                  wr_key_en_in  = 1'b0;
                  wr_val_en_in  = 1'b0;
                  cnt_inc_in    = 1'b0;
                  cnt_dec_in    = 1'b0;
                  state_in      = ST_OUTPUT;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            prod_in = PROD_W'(op_a) * PROD_W'(op_b);
            if (step_ff == 3'd1) acc_in = ACC_W'(prod_ff[FOLD_W-1:0]);
            else if (step_ff == 3'd2 || step_ff == 3'd3 || step_ff == 3'd4)
               acc_in = acc_ff + ACC_W'(prod_ff[FOLD_W-1:0]);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) state_in = ST_PROBE;
         end
         ST_PROBE: begin
            addr_in  = ADDR_W'(base_ff + ADDR_W'(rem));
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (match || last) begin
               res_read_in  = '0;
               wr_key_en_in = 1'b0;
               wr_val_en_in = 1'b0;
               cnt_inc_in   = 1'b0;
               cnt_dec_in   = 1'b0;
               wr_addr_in   = addr_ff;
               wr_key_in    = '0;
               case (kind_ff) inside
                  KIND_GET: begin
                     res_status_in = match ? STATUS_OK : STATUS_NOT_FOUND;
                     if (match) res_read_in = 32'(val_rd);
                  end
                  KIND_REMOVE: begin
                     res_status_in = match ? STATUS_OK : STATUS_NOT_FOUND;
                     wr_key_en_in  = match;
                     cnt_dec_in    = match;
                  end
                  KIND_SET, KIND_REPLACE: begin
                     if (match) begin
                        res_status_in = (kind_ff == KIND_SET) ? STATUS_EXISTS : STATUS_OK;
                        wr_val_en_in  = (kind_ff == KIND_REPLACE);
                     end else if (free_found_ff || empty) begin
                        res_status_in = STATUS_OK;
                        wr_key_en_in  = 1'b1;
                        wr_val_en_in  = 1'b1;
                        wr_key_in     = key_ff;
                        cnt_inc_in    = 1'b1;
                        wr_addr_in    = free_found_ff ? free_addr_ff : addr_ff;
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  default: res_status_in = STATUS_INVALID;
               endcase
               state_in = ST_OUTPUT;
            end else begin
               if (empty && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_addr_in  = addr_ff;
               end
               row_in   = ROW_W'(row_ff + ROW_W'(1));
               base_in  = ADDR_W'(base_ff + ADDR_W'(prime));
               step_in  = '0;
               state_in = ST_HASH;
            end
         end
         ST_OUTPUT: begin
            if (fire) begin
               if (cnt_inc_ff) count_in = COUNT_W'(count_ff + COUNT_W'(1));
               else if (cnt_dec_ff) count_in = COUNT_W'(count_ff - COUNT_W'(1));
               rsp_in.status      = res_status_ff;
               rsp_in.read_value  = res_read_ff;
               rsp_in.entry_count = 14'(count_in);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff        <= rsp_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      val_ff        <= val_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      addr_ff       <= addr_in;
      free_found_ff <= free_found_in;
      free_addr_ff  <= free_addr_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      wr_key_en_ff  <= wr_key_en_in;
      wr_val_en_ff  <= wr_val_en_in;
      wr_addr_ff    <= wr_addr_in;
      wr_key_ff     <= wr_key_in;
      cnt_inc_ff    <= cnt_inc_in;
      cnt_dec_ff    <= cnt_dec_in;
   end

   assign key_we    = clearing || (fire && wr_key_en_ff);
   assign key_waddr = clearing ? clr_ff : wr_addr_ff;
   assign key_wdata = clearing ? 64'd0 : wr_key_ff;

   // reads are issued in the probe cycle, data is compared in the check cycle
   mpht_ram #(.WIDTH(64), .DEPTH(TOTAL)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (addr_in),
      .rd_data (key_rd)
   );

   mpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(TOTAL)) u_val_ram (
      .clock   (clock),
      .wr_en   (fire && wr_val_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (val_ff),
      .rd_addr (addr_in),
      .rd_data (val_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rem_below_prime: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (rem_full < ACC_W'(prime)))
      else $error("row remainder not below its prime");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (addr_ff < ADDR_W'(TOTAL - 1) || addr_ff == ADDR_W'(TOTAL - 1)))
      else $error("probe address beyond the slot store");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff < COUNT_W'(TOTAL)) || (count_ff == COUNT_W'(TOTAL)))
      else $error("occupied count above slot total");

   a_single_count_step: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(cnt_inc_ff && cnt_dec_ff))
      else $error("count incremented and decremented together");

endmodule
